>>> hdl/bfa_pkg.sv
// Shared types and constants for the best-fit block allocator.
`timescale 1ns / 1ps

package bfa_pkg;

   // Default table depth and register reset value
   localparam int       NUM_BLOCKS_DEF = 16;
   localparam int       BIU_W          = 5;
   localparam [BIU_W-1:0] BIU_RESET    = 5'd16;

   // Item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_ALLOC = 1'b1;

   // Request beat
   typedef struct packed {
      logic        kind;
      logic [3:0]  block_index;
      logic [31:0] size;
   } req_type;

   // Result beat
   typedef struct packed {
      logic        granted;
      logic [3:0]  chosen_block;
      logic [31:0] remaining_size;
   } rsp_type;

   // Controls from the sequencer to the compare unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

>>> hdl/bfa_table.sv
// Free-size table: one write port, one read port with registered data.
`timescale 1ns / 1ps

module bfa_table
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
   parameter int IDX_W      = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [31:0]      wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [31:0]      rd_data
);

   logic [31:0] mem_ff [NUM_BLOCKS];
   logic [31:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bfa_scan.sv
// Shared compare unit: tracks the smallest entry that still fits the request.
`timescale 1ns / 1ps

module bfa_scan
   import bfa_pkg::*;
#(
   parameter int IDX_W = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  scan_ctl_type     ctl,
   input  logic [IDX_W-1:0] smp_idx,
   input  logic [31:0]      smp_val,
   input  logic [31:0]      req_size,
   output logic             found,
   output logic [IDX_W-1:0] best_idx,
   output logic [31:0]      best_val
);

   logic             found_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      best_val_ff;
   logic             take;

   // Fits, and strictly smaller than the best so far (ties keep lower index)
   assign take = ctl.sample && (smp_val >= req_size) &&
                 (!found_ff || (smp_val < best_val_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= smp_idx;
         best_val_ff <= smp_val;
      end
   end

   assign found    = found_ff;
   assign best_idx = best_idx_ff;
   assign best_val = best_val_ff;

endmodule

>>> hdl/best_fit_block_allocator_core.sv
// Best-fit block allocator: top level with the sequencer and result register.
//
// Input channel req_*: one beat is a load (kind 0: writes block_index's free size)
// or an allocation request (kind 1: size to place). Every beat gives one rsp_ beat.
// Config channel csr_*: writes blocks_in_use (entries searched, saturates at
// NUM_BLOCKS); always ready. The user must see that it is written only while
// the block is idle; the block itself does not enforce this. With rsp_ready
// high, a load goes from acceptance through the hand-off state into the output
// register; a request first scans the searched entries, then drains and writes
// back the reduced size before its hand-off. The search is bound by the table's
// single read port: one entry is read and fed to the one compare unit per cycle,
// then the drain state lets the last read be compared before the write-back.
// req_ready is high only while the sequencer is idle. A finished result sits in
// the output register; if the receiver stalls, the next item may still be
// taken and worked, and it waits only at its own hand-off.
// Reset clears the sequencer and the output valid flag and sets blocks_in_use
// to 16. Table contents are undefined until loaded; no clearing pass is run.
`timescale 1ns / 1ps

module best_fit_block_allocator_core
   import bfa_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [BIU_W-1:0] csr_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] limit_sat;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   rsp_type          result_ff, result_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BIU_W-1:0] biu_ff;

   logic             accept;
   logic             rsp_load;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0]      wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_data;
   scan_ctl_type     scan_ctl;
   logic             found;
   logic [IDX_W-1:0] best_idx;
   logic [31:0]      best_val;
   logic [31:0]      diff;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff <= BIU_RESET;
      end else if (csr_valid) begin
         biu_ff <= csr_data;
      end
   end

   // Search length, saturated to the table depth
   always_comb begin
      if (32'(biu_ff) > NUM_BLOCKS) begin
         limit_sat = CNT_W'(NUM_BLOCKS);
      end else begin
         limit_sat = CNT_W'(biu_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign diff      = best_val - item_ff.size;

   // Sequencer: next state and controls
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      cnt_in         = cnt_ff;
      limit_in       = limit_ff;
      result_in      = result_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      rd_en          = 1'b0;
      rd_addr        = cnt_ff[IDX_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = IDX_W'(req_data.block_index);
      wr_data        = req_data.size;
      scan_ctl.clear  = 1'b0;
      scan_ctl.sample = rd_valid_ff;
      rsp_load       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               if (req_data.kind == KIND_LOAD) begin
                  wr_en     = (32'(req_data.block_index) < NUM_BLOCKS);
                  result_in = '{granted: 1'b0, chosen_block: req_data.block_index,
                                remaining_size: req_data.size};
                  state_in  = ST_DONE;
               end else begin
                  cnt_in         = '0;
                  limit_in       = limit_sat;
                  scan_ctl.clear = 1'b1;
                  if (limit_sat == '0) begin
                     result_in = '0;
                     state_in  = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Issue one table read per cycle
            rd_en       = 1'b1;
            rd_valid_in = 1'b1;
            rd_idx_in   = cnt_ff[IDX_W-1:0];
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_in == limit_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // Last read is compared this cycle
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (found) begin
               wr_en     = 1'b1;
               wr_addr   = best_idx;
               wr_data   = diff;
               result_in = '{granted: 1'b1, chosen_block: 4'(best_idx),
                             remaining_size: diff};
            end else begin
               result_in = '0;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      cnt_ff    <= cnt_in;
      limit_ff  <= limit_in;
      rd_idx_ff <= rd_idx_in;
      result_ff <= result_in;
   end

   // Output register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in       = result_ff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   bfa_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfa_scan #(
      .IDX_W (IDX_W)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .smp_idx  (rd_idx_ff),
      .smp_val  (rd_data),
      .req_size (item_ff.size),
      .found    (found),
      .best_idx (best_idx),
      .best_val (best_val)
   );

   // Scan counter never runs past the search length
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (cnt_ff < limit_ff))
      else $error("scan counter past search length");

   // Read data only arrives while scanning or draining
   a_rd_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)))
      else $error("table read outside scan");

   // A grant never underflows the chosen entry
   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WRITE) && found) |-> (best_val >= item_ff.size))
      else $error("granted block smaller than request");

   // A new result is only presented from the hand-off state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result presented outside hand-off");

endmodule
